// ===== rtl/core/mhhd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mhhd_pkg
// Shared types and constants for the mecanum heading hold drive.
// ============================================================================
package mhhd_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_GAIN           = 3'd0,
        REG_MAX_COMMAND      = 3'd1,
        REG_MIN_COMMAND      = 3'd2,
        REG_HEADING_DEADBAND = 3'd3,
        REG_ROTATE_DEADBAND  = 3'd4,
        REG_HOLD_ENABLE      = 3'd5,
        REG_TRACK_ENABLE     = 3'd6,
        REG_TRACK_ANGLE      = 3'd7
    } t_cfg_index;

    // 1/sqrt2 in Q0.16
    localparam logic signed [17:0] INV_SQRT2_Q16 = 18'sd46341;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic signed [15:0] stick_rotate;
        logic signed [23:0] heading;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] fl_drive;
        logic signed [15:0] fr_drive;
        logic signed [15:0] rl_drive;
        logic signed [15:0] rr_drive;
        logic               target_met;
        logic               gyro_zero;
    } t_out_word;

    typedef struct packed {
        logic [15:0]        p_gain;
        logic [14:0]        max_command;
        logic [14:0]        min_command;
        logic [15:0]        heading_deadband;
        logic [14:0]        rotate_deadband;
        logic               hold_enable;
        logic               track_enable;
        logic signed [23:0] track_angle;
    } t_cfg;

    typedef struct packed {
        logic               hold_armed;
        logic signed [23:0] hold_heading;
        logic signed [15:0] prev_rotate;
        logic               met_flag;
    } t_hold_state;

    typedef struct packed {
        t_hold_state        next_state;
        logic signed [15:0] rotate;
        logic               zero_req;
    } t_rot_result;

endpackage

// ===== rtl/core/mecanum_heading_hold_drive.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mecanum_heading_hold_drive
// Mecanum wheel mixer with proportional heading hold / heading tracking.
// ============================================================================
// One word is accepted per clock and one result word leaves per clock when the
// output side keeps ready high. A word lands in the input register, and the hold
// logic, P controller and wheel mixer run in a single pass from there into the
// result register, which drives o_out_valid and o_out_word.
// Hold state (armed flag, captured heading, last applied rotation, target met)
// updates as each word leaves the input register, so consecutive words chain
// correctly. Configuration writes take effect at once; write only when idle.
module mecanum_heading_hold_drive
    import mhhd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    t_hold_state r_state;
    logic        r_in_valid;
    t_in_word    r_in_word;
    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;
    t_rot_result s_rot;
    logic        s_out_free;
    logic        s_advance;

    assign s_out_free  = !r_out_valid || i_out_ready;
    assign s_advance   = r_in_valid && s_out_free;
    assign o_in_ready  = !r_in_valid || s_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    mhhd_heading u_heading (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_stick_rotate (r_in_word.stick_rotate),
        .i_heading      (r_in_word.heading),
        .o_result       (s_rot)
    );

    mhhd_mix u_mix (
        .i_stick_x  (r_in_word.stick_x),
        .i_stick_y  (r_in_word.stick_y),
        .i_rotate   (s_rot.rotate),
        .o_fl_drive (n_out_word.fl_drive),
        .o_fr_drive (n_out_word.fr_drive),
        .o_rl_drive (n_out_word.rl_drive),
        .o_rr_drive (n_out_word.rr_drive)
    );

    assign n_out_word.target_met = s_rot.next_state.met_flag;
    assign n_out_word.gyro_zero  = s_rot.zero_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (s_advance) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain           <= 16'd256;
            r_cfg.max_command      <= 15'd16384;
            r_cfg.min_command      <= 15'd3277;
            r_cfg.heading_deadband <= 16'd128;
            r_cfg.rotate_deadband  <= 15'd1638;
            r_cfg.hold_enable      <= 1'b0;
            r_cfg.track_enable     <= 1'b0;
            r_cfg.track_angle      <= '0;
            r_state.hold_armed     <= 1'b0;
            r_state.hold_heading   <= '0;
            r_state.prev_rotate    <= '0;
            r_state.met_flag       <= 1'b1;
        end else begin
            if (s_advance) begin
                r_state <= s_rot.next_state;
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    REG_P_GAIN:           r_cfg.p_gain           <= i_cfg_data[15:0];
                    REG_MAX_COMMAND:      r_cfg.max_command      <= i_cfg_data[14:0];
                    REG_MIN_COMMAND:      r_cfg.min_command      <= i_cfg_data[14:0];
                    REG_HEADING_DEADBAND: r_cfg.heading_deadband <= i_cfg_data[15:0];
                    REG_ROTATE_DEADBAND:  r_cfg.rotate_deadband  <= i_cfg_data[14:0];
                    REG_HOLD_ENABLE:      r_cfg.hold_enable      <= i_cfg_data[0];
                    REG_TRACK_ENABLE:     r_cfg.track_enable     <= i_cfg_data[0];
                    REG_TRACK_ANGLE: begin
                        r_cfg.track_angle <= i_cfg_data[23:0];
                        r_state.met_flag  <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/mhhd_heading.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mhhd_heading
// Hold arm/disarm tracking and proportional heading controller; picks the
// rotation applied this tick and the next hold state.
// ============================================================================
module mhhd_heading
    import mhhd_pkg::*;
(
    input  t_cfg               i_cfg,
    input  t_hold_state        i_state,
    input  logic signed [15:0] i_stick_rotate,
    input  logic signed [23:0] i_heading,
    output t_rot_result        o_result
);

    logic [16:0]        s_rot_abs;
    logic [16:0]        s_prev_abs;
    logic               s_rot_out;
    logic               s_prev_out;
    logic               s_armed;
    logic signed [23:0] s_hold_hdg;
    logic signed [24:0] s_err;
    logic [24:0]        s_err_abs;
    logic               s_p_active;
    logic               s_inside;
    logic signed [41:0] s_prod;
    logic signed [41:0] s_cmd_full;
    logic signed [41:0] s_mx;
    logic signed [41:0] s_mn;
    logic signed [15:0] s_cmd;

    assign s_rot_abs  = i_stick_rotate[15] ? 17'(-18'(i_stick_rotate)) : 17'(i_stick_rotate);
    assign s_prev_abs = i_state.prev_rotate[15] ? 17'(-18'(i_state.prev_rotate))
                                                : 17'(i_state.prev_rotate);
    assign s_rot_out  = s_rot_abs  > {2'b00, i_cfg.rotate_deadband};
    assign s_prev_out = s_prev_abs > {2'b00, i_cfg.rotate_deadband};

    always_comb begin
        s_armed    = i_state.hold_armed;
        s_hold_hdg = i_state.hold_heading;
        if (s_rot_out) begin
            if (!s_prev_out) begin
                s_armed = 1'b0;
            end
        end else if (s_prev_out) begin
            s_armed    = 1'b1;
            s_hold_hdg = i_heading;
        end
    end

    always_comb begin
        if (i_cfg.track_enable) begin
            s_err = 25'(i_heading) - 25'(i_cfg.track_angle);
        end else if (s_armed) begin
            s_err = 25'(i_heading) - 25'(s_hold_hdg);
        end else begin
            s_err = '0;
        end
    end

    assign s_err_abs  = s_err[24] ? 25'(-s_err) : 25'(s_err);
    assign s_inside   = s_err_abs < {9'd0, i_cfg.heading_deadband};
    assign s_p_active = i_cfg.track_enable || (s_armed && i_cfg.hold_enable);

    assign s_prod     = 42'(s_err) * $signed({26'd0, i_cfg.p_gain});
    assign s_cmd_full = (s_prod + 42'sd128) >>> 8;
    assign s_mx       = $signed({27'd0, i_cfg.max_command});
    assign s_mn       = $signed({27'd0, i_cfg.min_command});

    always_comb begin
        if (s_inside) begin
            s_cmd = '0;
        end else if (s_cmd_full > s_mx) begin
            s_cmd = 16'(s_mx);
        end else if (s_cmd_full < s_mn && s_cmd_full > 42'sd0) begin
            s_cmd = 16'(s_mn);
        end else if (s_cmd_full > -s_mn && s_cmd_full < 42'sd0) begin
            s_cmd = 16'(-s_mn);
        end else if (s_cmd_full < -s_mx) begin
            s_cmd = 16'(-s_mx);
        end else begin
            s_cmd = 16'(s_cmd_full);
        end
    end

    always_comb begin
        o_result.zero_req                = s_rot_out;
        o_result.next_state.hold_armed   = s_armed;
        o_result.next_state.hold_heading = s_hold_hdg;
        o_result.next_state.met_flag     = s_p_active ? s_inside : i_state.met_flag;
        o_result.rotate                  = s_p_active ? s_cmd : i_stick_rotate;
        o_result.next_state.prev_rotate  = o_result.rotate;
    end

endmodule

// ===== rtl/core/mhhd_mix.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mhhd_mix
// Mecanum wheel mixing: rotated translation plus/minus rotation, saturated.
// ============================================================================
module mhhd_mix
    import mhhd_pkg::*;
(
    input  logic signed [15:0] i_stick_x,
    input  logic signed [15:0] i_stick_y,
    input  logic signed [15:0] i_rotate,
    output logic signed [15:0] o_fl_drive,
    output logic signed [15:0] o_fr_drive,
    output logic signed [15:0] o_rl_drive,
    output logic signed [15:0] o_rr_drive
);

    logic signed [17:0] s_xmy;
    logic signed [17:0] s_nxpy;
    logic signed [35:0] s_prod_a;
    logic signed [35:0] s_prod_b;
    logic signed [35:0] s_a_full;
    logic signed [35:0] s_b_full;
    logic signed [18:0] s_a;
    logic signed [18:0] s_b;
    logic signed [18:0] s_rot;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    assign s_xmy    = 18'(i_stick_x) - 18'(i_stick_y);
    assign s_nxpy   = -(18'(i_stick_x) + 18'(i_stick_y));
    assign s_prod_a = 36'(s_xmy) * 36'(INV_SQRT2_Q16);
    assign s_prod_b = 36'(s_nxpy) * 36'(INV_SQRT2_Q16);
    assign s_a_full = (s_prod_a + 36'sd32768) >>> 16;
    assign s_b_full = (s_prod_b + 36'sd32768) >>> 16;
    assign s_a      = 19'(s_a_full);
    assign s_b      = 19'(s_b_full);
    assign s_rot    = 19'(i_rotate);

    assign o_fl_drive = sat16(s_a + s_rot);
    assign o_fr_drive = sat16(s_b - s_rot);
    assign o_rl_drive = sat16(s_b + s_rot);
    assign o_rr_drive = sat16(s_a - s_rot);

endmodule

// ===== test/mhhd_drive_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mhhd_drive_checker
// Watches the input, output and configuration ports of the heading hold
// drive, predicts each wheel result word from its own copy of the hold state
// and settings, and compares every output word field by field.
// ============================================================================
module mhhd_drive_checker
    import mhhd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam longint ROOT_HALF_Q16 = 46341;

    // settings
    longint gain, max_cmd, min_cmd, hdg_db, rot_db, trk_angle;
    bit     hold_en, trk_en;

    // hold state
    bit     armed;
    longint held_heading;
    longint last_rot;
    bit     met;

    t_out_word wheel_q[$];
    int        mismatches;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // divide by 2^k, nearest, ties up
    function automatic longint round_div(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (t_cfg_index'(idx))
            REG_P_GAIN:           gain    = data[15:0];
            REG_MAX_COMMAND:      max_cmd = data[14:0];
            REG_MIN_COMMAND:      min_cmd = data[14:0];
            REG_HEADING_DEADBAND: hdg_db  = data[15:0];
            REG_ROTATE_DEADBAND:  rot_db  = data[14:0];
            REG_HOLD_ENABLE:      hold_en = data[0];
            REG_TRACK_ENABLE:     trk_en  = data[0];
            REG_TRACK_ANGLE: begin
                trk_angle = longint'($signed(data[23:0]));
                met = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic predict_wheels(input t_in_word w, output t_out_word r);
        longint x, y, rot, hdg, err, cmd, a, b;
        bit     zero_req;
        x        = w.stick_x;
        y        = w.stick_y;
        rot      = w.stick_rotate;
        hdg      = w.heading;
        zero_req = 1'b0;
        err      = 0;
        if (mag(rot) > rot_db) begin
            if (mag(last_rot) <= rot_db) armed = 1'b0;
            zero_req = 1'b1;
        end else if (mag(last_rot) > rot_db) begin
            armed        = 1'b1;
            held_heading = hdg;
        end
        if (trk_en) err = hdg - trk_angle;
        else if (armed) err = hdg - held_heading;
        if (trk_en || (armed && hold_en)) begin
            if (mag(err) < hdg_db) begin
                cmd = 0;
                met = 1'b1;
            end else begin
                cmd = round_div(gain * err, 8);
                if (cmd > max_cmd) cmd = max_cmd;
                else if (cmd > 0 && cmd < min_cmd) cmd = min_cmd;
                else if (cmd < 0 && cmd > -min_cmd) cmd = -min_cmd;
                else if (cmd < -max_cmd) cmd = -max_cmd;
                met = 1'b0;
            end
            rot = cmd;
        end
        a = round_div((x - y) * ROOT_HALF_Q16, 16);
        b = round_div(-(x + y) * ROOT_HALF_Q16, 16);
        r.fl_drive   = clip16(a + rot);
        r.fr_drive   = clip16(b - rot);
        r.rl_drive   = clip16(b + rot);
        r.rr_drive   = clip16(a - rot);
        r.target_met = met;
        r.gyro_zero  = zero_req;
        last_rot     = rot;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s wrong in result word: expected %0d, got %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want_w;
        if (!i_rst_n) begin
            gain         = 256;
            max_cmd      = 16384;
            min_cmd      = 3277;
            hdg_db       = 128;
            rot_db       = 1638;
            hold_en      = 1'b0;
            trk_en       = 1'b0;
            trk_angle    = 0;
            armed        = 1'b0;
            held_heading = 0;
            last_rot     = 0;
            met          = 1'b1;
            mismatches   = 0;
            wheel_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) apply_setting(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                if (wheel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing expected", $time);
                end else begin
                    want_w = wheel_q.pop_front();
                    check_field("fl_drive", want_w.fl_drive, i_out_word.fl_drive);
                    check_field("fr_drive", want_w.fr_drive, i_out_word.fr_drive);
                    check_field("rl_drive", want_w.rl_drive, i_out_word.rl_drive);
                    check_field("rr_drive", want_w.rr_drive, i_out_word.rr_drive);
                    check_field("target_met", want_w.target_met, i_out_word.target_met);
                    check_field("gyro_zero", want_w.gyro_zero, i_out_word.gyro_zero);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_wheels(i_in_word, want_w);
                wheel_q.insert(wheel_q.size(), want_w);
            end
            o_pending    <= wheel_q.size();
            o_fail_count <= mismatches;
        end
    end

endmodule

// ===== test/mecanum_heading_hold_drive_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mecanum_heading_hold_drive_tb
// Drives joystick and heading words into the heading hold drive with random
// gaps and output stalls, across directed cases and randomized settings; a
// checker beside the block predicts and compares every wheel result word.
// ============================================================================
module mecanum_heading_hold_drive_tb;
    import mhhd_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  in_ready;
    t_in_word              i_in_word = '0;
    logic                  out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             out_word;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;

    bit gaps_on = 1'b1;
    int hold_off_cycles = 0;

    // current phase settings, used to aim the stimulus
    int cur_rdb;
    int cur_hdb;
    int base_hdg;

    always #10 i_clk = ~i_clk;

    mecanum_heading_hold_drive u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mhhd_drive_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (out_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_field(int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 30) return hi;
        return $urandom_range(0, hi);
    endfunction

    function automatic int clamp_hdg(int h);
        if (h > 8388607) return 8388607;
        if (h < -8388608) return -8388608;
        return h;
    endfunction

    task automatic put_cfg(input t_cfg_index idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drive_tick(input int x, input int y, input int r, input int h);
        t_in_word w;
        int       g;
        w.stick_x      = 16'(x);
        w.stick_y      = 16'(y);
        w.stick_rotate = 16'(r);
        w.heading      = 24'(h);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_phase(input int p);
        int gain, mx, mn, hold, trk, angle;
        base_hdg = int'($urandom_range(0, 8000000)) - 4000000;
        if (p == 0) begin
            gain = 0; mx = 0; mn = 0; cur_hdb = 0; cur_rdb = 0;
            hold = 1; trk = 1; angle = -8388608; base_hdg = -8388608;
        end else if (p == 1) begin
            gain = 65535; mx = 32767; mn = 32767; cur_hdb = 65535; cur_rdb = 32767;
            hold = 1; trk = 1; angle = 8388607; base_hdg = 8388607;
        end else begin
            gain    = $urandom_range(0, 1) ? pick_field(65535) : $urandom_range(1, 1024);
            mx      = pick_field(32767);
            mn      = $urandom_range(0, 1) ? pick_field(32767) : $urandom_range(0, 4000);
            cur_hdb = $urandom_range(0, 1) ? pick_field(65535) : $urandom_range(0, 600);
            cur_rdb = ($urandom_range(0, 3) == 0) ? pick_field(32767)
                                                   : $urandom_range(200, 6000);
            hold    = ($urandom_range(0, 3) != 0);
            trk     = ($urandom_range(0, 2) == 0);
            angle   = base_hdg + int'($urandom_range(0, 2000)) - 1000;
        end
        put_cfg(REG_P_GAIN, gain);
        put_cfg(REG_MAX_COMMAND, mx);
        put_cfg(REG_MIN_COMMAND, mn);
        put_cfg(REG_HEADING_DEADBAND, cur_hdb);
        put_cfg(REG_ROTATE_DEADBAND, cur_rdb);
        put_cfg(REG_HOLD_ENABLE, hold);
        put_cfg(REG_TRACK_ENABLE, trk);
        put_cfg(REG_TRACK_ANGLE, angle);
    endtask

    task automatic random_tick();
        int x, y, r, h, sel, outer, spread;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            r = int'($urandom_range(0, 2 * cur_rdb)) - cur_rdb;
        end else if (sel < 90) begin
            outer = $urandom_range(cur_rdb + 1, 32768);
            r = $urandom_range(0, 1) ? -outer : ((outer > 32767) ? 32767 : outer);
        end else begin
            r = $urandom();
        end
        sel    = $urandom_range(0, 99);
        spread = 3 * cur_hdb + 400;
        if (sel < 60)
            h = clamp_hdg(base_hdg + int'($urandom_range(0, 2 * spread)) - spread);
        else if (sel < 85)
            h = clamp_hdg(base_hdg + int'($urandom_range(0, 400000)) - 200000);
        else
            h = int'($urandom() << 8) >>> 8;
        if ($urandom_range(0, 3) != 0) begin
            x = $urandom();
            y = $urandom();
        end else begin
            x = ($urandom_range(0, 1)) ? -32768 : 32767;
            y = int'($urandom_range(0, 64)) - 32;
        end
        drive_tick(x, y, r, h);
    endtask

    // output side: random stalls, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else if (!gaps_on || $urandom_range(0, 99) < 80) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(0, 7)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
                repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extremes, manual rotation, hold arming
        drive_tick(0, 0, 0, 0);
        drive_tick(32767, -32768, 0, 8388607);
        drive_tick(-32768, 32767, 0, -8388608);
        drive_tick(-32768, -32768, 0, 0);
        drive_tick(32767, 32767, 32767, 0);
        drive_tick(0, 0, -32768, 0);
        drive_tick(0, 0, 0, 1000);
        drain();

        // armed hold drives rotation: deadband, min, max, manual break-in
        put_cfg(REG_HOLD_ENABLE, 1);
        drive_tick(100, 200, 0, 1000);
        drive_tick(0, 0, 0, 1100);
        drive_tick(0, 0, 0, 1200);
        drive_tick(0, 0, 0, 700);
        drive_tick(0, 0, 0, 100000);
        drive_tick(0, 0, 0, -100000);
        drive_tick(0, 0, 0, 1128);
        drive_tick(0, 0, 20000, 1128);
        drive_tick(0, 0, 0, 5000);
        drain();

        // tracking over an armed hold, min above max, zero after rounding
        put_cfg(REG_P_GAIN, 1);
        put_cfg(REG_MAX_COMMAND, 5000);
        put_cfg(REG_MIN_COMMAND, 20000);
        put_cfg(REG_HEADING_DEADBAND, 0);
        put_cfg(REG_TRACK_ENABLE, 1);
        put_cfg(REG_TRACK_ANGLE, -8388608);
        drive_tick(0, 0, 0, 8388607);
        drive_tick(0, 0, 0, -8388408);
        drive_tick(0, 0, 0, -8388508);
        drive_tick(0, 0, 0, -8388608);
        drive_tick(1000, -1000, 32767, -8388608);
        drain();

        for (int p = 0; p < 12; p++) begin
            gaps_on = (p % 4 != 3);
            program_phase(p);
            if (p == 4) hold_off_cycles = 300;
            repeat (127) random_tick();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("mecanum_heading_hold_drive_tb: PASS");
        end else begin
            $display("mecanum_heading_hold_drive_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("mecanum_heading_hold_drive_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mhhd_pkg.sv
rtl/core/mhhd_heading.sv
rtl/core/mhhd_mix.sv
rtl/core/mecanum_heading_hold_drive.sv
test/mhhd_drive_checker.sv
test/mecanum_heading_hold_drive_tb.sv
